// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the block.
// Self-contained; take it in by include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// File: rtl/lccp_pkg.sv
// Package for the lattice coefficient compressor: widths, constants, control struct.
// No dependencies; every other file of the block but assert_macros.svh imports it.
package lccp_pkg;

    localparam int LANES       = 8;
    localparam int MODULUS     = 3329;
    localparam int TWO_Q       = 2 * MODULUS;
    localparam int COEFF_W     = 12;
    localparam int CODE_W      = 11;
    localparam int NUM_W       = 24;
    localparam int QUOT_W      = 12;
    localparam int PROD_W      = 48;
    localparam int RECIP_SHIFT = 36;
    localparam longint RECIP   = (longint'(1) << RECIP_SHIFT) / TWO_Q;

    localparam int CFG_W       = 4;
    localparam int LOW_W       = 64;
    localparam int HIGH_W      = 24;
    localparam int COUNT_W     = 4;
    localparam int PACK_W      = LOW_W + HIGH_W;
    localparam int IN_TDATA_W  = LANES * COEFF_W;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_PAD_W   = OUT_TDATA_W - PACK_W - COUNT_W;

    localparam logic [CFG_W-1:0] BITS_NARROW = 4'd10;
    localparam logic [CFG_W-1:0] BITS_WIDE   = 4'd11;

    typedef struct packed {
        logic valid;
        logic d11;
    } lccp_ctrl_t;

endpackage

// File: rtl/lattice_coeff_compress_pack.sv
// Three register stages; a result is offered from the output register, behind the two lane registers.
// Throughput: one item per cycle; the pipeline halts only while a held result waits.
// Stages: lane multiply, lane correction, pack into the output register.
// Reset (rst_n low, asynchronous): pipeline emptied, compressed_bits set to 10.
// Depends on lccp_pkg, lccp_lane and lccp_pack.
module lattice_coeff_compress_pack (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration: compressed_bits
    input  logic                             cfg_we,
    input  logic [lccp_pkg::CFG_W-1:0]       cfg_wdata,
    // input items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // coeff_0 [11:0], coeff_1 [23:12], ... coeff_7 [95:84]
    input  logic [lccp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // result items
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // packed_low [63:0], packed_high [87:64], byte_count [91:88], zero [95:92]
    output logic [lccp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import lccp_pkg::*;

    logic [CFG_W-1:0]                 bits_reg;
    logic                             d11;
    logic                             en;
    lccp_ctrl_t                       s1_reg;
    lccp_ctrl_t                       s2_reg;
    logic [LANES-1:0][CODE_W-1:0]     codes;
    logic                             out_valid;
    logic [LOW_W-1:0]                 packed_low;
    logic [HIGH_W-1:0]                packed_high;
    logic [COUNT_W-1:0]               byte_count;

    // Hold the width register; only eleven selects the wide mode.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= BITS_NARROW;
        end
        else if (cfg_we)
        begin
            bits_reg <= cfg_wdata;
        end
    end

    assign d11 = (bits_reg == BITS_WIDE);

    // Advance every stage together unless the output register holds an unread item.
    // Bubbles move along with the items, so the input side stays open every cycle
    // the result side takes.
    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // Valid and mode travel beside the lane data, one register per stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else if (en)
        begin
            s1_reg <= '{valid: s_axis_tvalid, d11: d11};
            s2_reg <= s1_reg;
        end
    end

    // Eight lanes work on the eight coefficients side by side.
    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        lccp_lane u_lane (
            .clk   (clk),
            .en    (en),
            .d11   (d11),
            .coeff (s_axis_tdata[j*COEFF_W +: COEFF_W]),
            .code  (codes[j])
        );
    end

    // Merge the lane codes into the packed byte stream.
    lccp_pack u_pack (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .ctrl        (s2_reg),
        .codes       (codes),
        .out_valid   (out_valid),
        .packed_low  (packed_low),
        .packed_high (packed_high),
        .byte_count  (byte_count)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, byte_count, packed_high, packed_low};

endmodule

// File: rtl/lccp_lane.sv
// One compression lane: reciprocal multiply, then correction and mask to d bits.
// Depends on lccp_pkg.
module lccp_lane (
    input  logic                         clk,
    input  logic                         en,
    input  logic                         d11,
    input  logic [lccp_pkg::COEFF_W-1:0] coeff,
    output logic [lccp_pkg::CODE_W-1:0]  code
);
    import lccp_pkg::*;

    logic [NUM_W-2:0]  shifted;
    logic [NUM_W-1:0]  num;
    logic [PROD_W-1:0] prod;
    logic [NUM_W-1:0]  num_reg;
    logic [QUOT_W-1:0] quot_est_reg;
    logic              d11_reg;
    logic [NUM_W-1:0]  back;
    logic [NUM_W-1:0]  rem;
    logic [QUOT_W-1:0] quot;
    logic [CODE_W-1:0] code_next;
    logic [CODE_W-1:0] code_reg;

    // numerator 2*(x << d) + q; quotient by 2q rounds half up
    always_comb
    begin
        shifted = d11 ? {coeff, 11'b0} : {1'b0, coeff, 10'b0};
        num     = {shifted, 1'b0} + NUM_W'(MODULUS);
        prod    = PROD_W'(num) * PROD_W'(RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg      <= num;
            quot_est_reg <= prod[RECIP_SHIFT +: QUOT_W];
            d11_reg      <= d11;
        end
    end

    // estimate is exact or one short: one compare and step up
    always_comb
    begin
        back      = NUM_W'(quot_est_reg) * NUM_W'(TWO_Q);
        rem       = num_reg - back;
        quot      = (rem >= NUM_W'(TWO_Q)) ? quot_est_reg + QUOT_W'(1) : quot_est_reg;
        code_next = d11_reg ? quot[CODE_W-1:0] : {1'b0, quot[CODE_W-2:0]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            code_reg <= code_next;
        end
    end

    assign code = code_reg;

endmodule

// File: rtl/lccp_pack.sv
// Merging stage: packs the lane codes little-endian into bytes and holds the result.
// Depends on lccp_pkg.
module lccp_pack (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         en,
    input  lccp_pkg::lccp_ctrl_t                         ctrl,
    input  logic [lccp_pkg::LANES-1:0][lccp_pkg::CODE_W-1:0] codes,
    output logic                                         out_valid,
    output logic [lccp_pkg::LOW_W-1:0]                   packed_low,
    output logic [lccp_pkg::HIGH_W-1:0]                  packed_high,
    output logic [lccp_pkg::COUNT_W-1:0]                 byte_count
);
    import lccp_pkg::*;

    logic [LANES*(CODE_W-1)-1:0] pack10;
    logic [LANES*CODE_W-1:0]     pack11;
    logic [PACK_W-1:0]           pack_next;
    logic                        valid_reg;
    logic [PACK_W-1:0]           pack_reg;
    logic [COUNT_W-1:0]          count_reg;

    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            pack10[j*(CODE_W-1) +: (CODE_W-1)] = codes[j][CODE_W-2:0];
            pack11[j*CODE_W +: CODE_W]         = codes[j];
        end
        pack_next = ctrl.d11 ? PACK_W'(pack11) : PACK_W'(pack10);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pack_reg  <= pack_next;
            count_reg <= ctrl.d11 ? BITS_WIDE : BITS_NARROW;
        end
    end

    assign out_valid   = valid_reg;
    assign packed_low  = pack_reg[LOW_W-1:0];
    assign packed_high = pack_reg[PACK_W-1:LOW_W];
    assign byte_count  = count_reg;

endmodule

// File: rtl/lccp_checker.sv
// Port-level checker for the compressor, bound to the top level below.
// Depends on lccp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lccp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [lccp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import lccp_pkg::*;

    logic                 out_stall;
    logic                 narrow_out;
    logic [COUNT_W-1:0]   count_field;
    logic [7:0]           byte10_field;
    logic [OUT_PAD_W-1:0] pad_field;

    assign out_stall    = m_axis_tvalid && !m_axis_tready;
    assign count_field  = m_axis_tdata[PACK_W +: COUNT_W];
    assign byte10_field = m_axis_tdata[PACK_W-1 -: 8];
    assign pad_field    = m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W];
    assign narrow_out   = m_axis_tvalid && (count_field == BITS_NARROW);

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // input side closes only behind a held result
    `ASSERT_IMPLY(a_ready_open, clk, rst_n, !s_axis_tready, out_stall)

    // byte count is ten or eleven
    `ASSERT_IMPLY(a_count, clk, rst_n, m_axis_tvalid, count_field == BITS_NARROW || count_field == BITS_WIDE)

    // ten-byte mode leaves byte 10 and the padding clear
    `ASSERT_IMPLY(a_narrow_zero, clk, rst_n, narrow_out, byte10_field == 8'd0 && pad_field == '0)

endmodule

bind lattice_coeff_compress_pack lccp_checker u_checker (.*);
